[design/b64_pkg.sv]
// Shared types, codes and alphabet functions for the base64 codec.
// No dependencies; every other design file refers to this package by scoped names.

package b64_pkg;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Status codes carried on the output tuser
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One job: up to four output words, index of the final word, status
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      status;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // Decoded alphabet symbol
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sym;

    // Map a 6-bit value to its alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'(8'h41 + {2'b00, v});
        end else if (v < 6'd52) begin
            c = 8'(8'h61 + {2'b00, v} - 8'd26);
        end else if (v < 6'd62) begin
            c = 8'(8'h30 + {2'b00, v} - 8'd52);
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Map a character to its 6-bit value; ok is low outside the alphabet
    function automatic t_sym dec_symbol(input logic [7:0] c);
        t_sym s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

[design/base64_codec_unit.sv]
// Top level of the streaming base64 codec (standard alphabet, '=' padding).
// Depends on b64_pkg, b64_front, b64_queue and b64_back.

// Write the direction bit (0 encode, 1 decode) while the stream is idle; a
// write also clears any partial group. The input side takes one word per cycle
// as long as the job queue between front and back has room, and the output
// side delivers one word per cycle from a registered stage while the receiver
// is ready. Decoding takes one character a cycle and gives up to three bytes
// per four characters; encoding gives four characters per three bytes, so the
// output port limits the sustained encode rate. A completed group passes
// through the job queue and then the output register. Errors (bad character,
// short stream) appear as one word with tlast set and the code on tuser.

module base64_codec_unit #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    b64_pkg::t_job    w_job;
    b64_pkg::t_job    w_head;
    b64_pkg::t_q_stat w_stat;

    assign s_axis_tready = !w_stat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    b64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_stat        (w_stat),
        .o_pop         (w_pop),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A job is never pushed into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_stat.full)
        else $error("job pushed into full queue");

    // A job is never popped from an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_stat.valid)
        else $error("job popped from empty queue");

    // An error word is always the final word of its job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != b64_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error word without tlast");

endmodule

[design/b64_front.sv]
// Front part of the base64 codec: accepts input words, keeps the group state
// and turns each completed group or error into a job. Depends on b64_pkg.

module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output b64_pkg::t_job o_job
);

    logic        r_dir;
    logic [23:0] r_group;
    logic [1:0]  r_fill;
    logic [1:0]  r_pad;
    logic [23:0] n_group;
    logic [1:0]  n_fill;
    logic [1:0]  n_pad;

    // Encode path signals
    logic [1:0]  w_f;
    logic [1:0]  w_f1;
    logic [23:0] w_egroup;
    // Decode path signals
    b64_pkg::t_sym w_sym;
    logic          w_is_pad;
    logic          w_bad;
    logic [23:0]   w_dgroup;
    logic [1:0]    w_fill1;
    logic [1:0]    w_pad1;
    logic [1:0]    w_padcap;

    // Work out the next group state and the job for this word
    always_comb begin
        n_group = r_group;
        n_fill  = r_fill;
        n_pad   = r_pad;
        o_push  = 1'b0;
        o_job   = '0;

        w_f = (r_fill > 2'd2) ? 2'd0 : r_fill;
        unique case (w_f)
            2'd0:    w_egroup = {i_byte, 16'h0000};
            2'd1:    w_egroup = r_group | {8'h00, i_byte, 8'h00};
            default: w_egroup = r_group | {16'h0000, i_byte};
        endcase
        w_f1 = 2'(w_f + 2'd1);

        w_is_pad = (i_byte == b64_pkg::PAD_CHAR);
        w_sym    = b64_pkg::dec_symbol(i_byte);
        w_bad    = w_is_pad ? (r_fill < 2'd2) : (!w_sym.ok || r_pad != 2'd0);
        w_dgroup = {r_group[17:0], (w_is_pad ? 6'd0 : w_sym.val)};
        w_fill1  = 2'(r_fill + 2'd1);
        w_pad1   = w_is_pad ? 2'(r_pad + 2'd1) : r_pad;
        w_padcap = (w_pad1 > 2'd2) ? 2'd2 : w_pad1;

        if (i_accept) begin
            if (r_dir == b64_pkg::DIR_ENCODE) begin
                if (w_f1 == 2'd3 || i_last) begin
                    // emit four characters, pad past the filled bytes
                    o_push         = 1'b1;
                    o_job.last_idx = 2'd3;
                    o_job.status   = b64_pkg::ST_OK;
                    o_job.bytes[0] = b64_pkg::enc_char(w_egroup[23:18]);
                    o_job.bytes[1] = b64_pkg::enc_char(w_egroup[17:12]);
                    o_job.bytes[2] = (w_f1 >= 2'd2) ? b64_pkg::enc_char(w_egroup[11:6])
                                                    : b64_pkg::PAD_CHAR;
                    o_job.bytes[3] = (w_f1 == 2'd3) ? b64_pkg::enc_char(w_egroup[5:0])
                                                    : b64_pkg::PAD_CHAR;
                    n_group = '0;
                    n_fill  = '0;
                    n_pad   = '0;
                end else begin
                    n_group = w_egroup;
                    n_fill  = w_f1;
                end
            end else begin
                priority if (w_bad) begin
                    o_push       = 1'b1;
                    o_job.status = b64_pkg::ST_BADCHAR;
                    n_group = '0;
                    n_fill  = '0;
                    n_pad   = '0;
                end else if (w_fill1 == 2'd0) begin
                    // full group: three bytes less one per pad
                    o_push         = 1'b1;
                    o_job.status   = b64_pkg::ST_OK;
                    o_job.last_idx = 2'(2'd2 - w_padcap);
                    o_job.bytes[0] = w_dgroup[23:16];
                    o_job.bytes[1] = w_dgroup[15:8];
                    o_job.bytes[2] = w_dgroup[7:0];
                    n_group = '0;
                    n_fill  = '0;
                    n_pad   = '0;
                end else if (i_last) begin
                    o_push       = 1'b1;
                    o_job.status = b64_pkg::ST_SHORT;
                    n_group = '0;
                    n_fill  = '0;
                    n_pad   = '0;
                end else begin
                    n_group = w_dgroup;
                    n_fill  = w_fill1;
                    n_pad   = w_pad1;
                end
            end
        end
    end

    // Hold direction and group state; a direction write clears the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= b64_pkg::DIR_ENCODE;
            r_group <= '0;
            r_fill  <= '0;
            r_pad   <= '0;
        end else if (i_cfg_we) begin
            r_dir   <= i_cfg_wdata;
            r_group <= '0;
            r_fill  <= '0;
            r_pad   <= '0;
        end else begin
            r_group <= n_group;
            r_fill  <= n_fill;
            r_pad   <= n_pad;
        end
    end

endmodule

[design/b64_queue.sv]
// Short job queue between the front and back parts of the base64 codec.
// Depends on b64_pkg for the job and status types.

module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64_pkg::t_job    i_job,
    input  logic             i_pop,
    output b64_pkg::t_job    o_head,
    output b64_pkg::t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.valid = (r_count != '0);

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

[design/b64_back.sv]
// Back part of the base64 codec: walks the head job one word per cycle, while
// the receiver is ready, into the registered output stream. Depends on b64_pkg.

module b64_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64_pkg::t_job    i_head,
    input  b64_pkg::t_q_stat i_stat,
    output logic             o_pop,
    input  logic             m_axis_tready,
    output logic             m_axis_tvalid,
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic [1:0] r_user;
    logic       w_advance;
    logic       w_load;

    assign w_advance = !r_valid || m_axis_tready;
    assign w_load    = w_advance && i_stat.valid;
    assign o_pop     = w_load && (r_idx == i_head.last_idx);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_user;

    // Load the next word of the head job when the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_advance) begin
            r_valid <= i_stat.valid;
            if (w_load) begin
                r_idx <= o_pop ? 2'd0 : 2'(r_idx + 2'd1);
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_head.bytes[r_idx];
            r_last <= (r_idx == i_head.last_idx);
            r_user <= i_head.status;
        end
    end

endmodule

[tb/base64_codec_unit_tb.sv]
// Self-checking testbench for base64_codec_unit: encode and decode streams with random idling.
// Depends on b64_pkg and the base64_codec_unit RTL; needs nothing else.
`timescale 1ns / 100ps

typedef logic [7:0] b64_byte_q_t[$];

typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
} b64_word_t;

// Tracks the codec group state and holds the words the block owes us
class b64_word_checker;
    static string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        direction;
    logic [23:0] group_bits;
    logic [1:0]  fill_count;
    logic [1:0]  pad_count;
    b64_word_t   expected_words[$];
    int          mismatches;

    function new();
        direction  = b64_pkg::DIR_ENCODE;
        mismatches = 0;
        clear_group();
    endfunction

    function void clear_group();
        group_bits = '0;
        fill_count = '0;
        pad_count  = '0;
    endfunction

    // A register write drops any partial group
    function void set_direction(logic dir);
        direction = dir;
        clear_group();
    endfunction

    static function logic [7:0] b64_char(logic [5:0] v);
        return ALPHABET[v];
    endfunction

    // Search the alphabet; return 0 for a character outside it
    static function bit b64_value(logic [7:0] c, output logic [5:0] v);
        v = '0;
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[i] == c) begin
                v = 6'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void push_word(logic [7:0] data, logic last, logic [1:0] status);
        b64_word_t w;
        w.data   = data;
        w.last   = last;
        w.status = status;
        expected_words.push_back(w);
    endfunction

    // Errors give a single zero word with tlast and restart the group
    function void push_fault(logic [1:0] status);
        push_word(8'h00, 1'b1, status);
        clear_group();
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Work out the words caused by one accepted input word
    function void accept_input(logic [7:0] b, logic last);
        int         f;
        int         n_bytes;
        logic [5:0] sextet;
        bit         valid_sym;
        if (direction == b64_pkg::DIR_ENCODE) begin
            f = fill_count;
            if (f > 2) f = 0;
            if (f == 0) group_bits = '0;
            group_bits = group_bits | (24'(b) << (16 - 8 * f));
            f++;
            if (f == 3 || last) begin
                // data characters first, then '=' up to four
                for (int k = 0; k < 4; k++) begin
                    if (k <= f) begin
                        push_word(b64_char(6'(group_bits >> (18 - 6 * k))), k == 3,
                                  b64_pkg::ST_OK);
                    end else begin
                        push_word(b64_pkg::PAD_CHAR, k == 3, b64_pkg::ST_OK);
                    end
                end
                clear_group();
            end else begin
                fill_count = 2'(f);
            end
        end else begin
            valid_sym = b64_value(b, sextet);
            if (b == b64_pkg::PAD_CHAR) begin
                // padding only allowed in the third and fourth place
                if (fill_count < 2) begin
                    push_fault(b64_pkg::ST_BADCHAR);
                    return;
                end
                pad_count = pad_count + 2'd1;
                sextet    = '0;
            end else if (!valid_sym || pad_count != 0) begin
                push_fault(b64_pkg::ST_BADCHAR);
                return;
            end
            group_bits = {group_bits[17:0], sextet};
            fill_count = fill_count + 2'd1;
            if (fill_count == 0) begin
                // drop one byte per pad character
                n_bytes = 3 - ((pad_count > 2) ? 2 : int'(pad_count));
                for (int k = 0; k < n_bytes; k++) begin
                    push_word(8'(group_bits >> (16 - 8 * k)), k == n_bytes - 1,
                              b64_pkg::ST_OK);
                end
                clear_group();
            end else if (last) begin
                push_fault(b64_pkg::ST_SHORT);
            end
        end
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare one output word against the oldest expected word
    task check_word(logic [7:0] data, logic last, logic [1:0] status);
        b64_word_t w;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%02h last=%0b status=%0d",
                                      data, last, status));
        end else begin
            w = expected_words.pop_front();
            if (data !== w.data)
                report_mismatch($sformatf("data %02h, want %02h", data, w.data));
            if (last !== w.last)
                report_mismatch($sformatf("tlast %0b, want %0b", last, w.last));
            if (status !== w.status)
                report_mismatch($sformatf("status %0d, want %0d", status, w.status));
        end
    endtask
endclass

module base64_codec_unit_tb;
    localparam realtime CLK_PERIOD = 12ns;
    localparam int      LONG_HOLD  = 150;
    localparam int      SETTLE     = 8;
    localparam int      PHASE_SIZE = 40;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_wdata   = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;            // [1:0] status

    b64_word_checker checker_h = new();

    int          items_sent    = 0;
    int          burst_left    = 0;
    bit          gaps_on       = 1'b0;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  ready_phase   = '0;
    int          hold_requests = 0;
    int          hold_taken    = 0;
    int          hold_left     = 0;

    base64_codec_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: stall on a rotating pattern, or hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_taken != hold_requests) begin
            hold_taken    <= hold_requests;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ready_pattern[ready_phase];
        end
        ready_phase <= ready_phase + 4'd1;
    end

    // Check every word the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            checker_h.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Offer one word, wait for the handshake, then maybe idle before the next
    task automatic send_word(logic [7:0] b, logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        checker_h.accept_input(b, last);
        items_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_bytes(b64_byte_q_t q, bit last_on_end);
        foreach (q[i]) send_word(q[i], last_on_end && (i == q.size() - 1));
    endtask

    task automatic send_text(string s, bit last_on_end);
        b64_byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_bytes(q, last_on_end);
    endtask

    // Stop offering, wait for all owed words, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_direction(logic dir);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        checker_h.set_direction(dir);
    endtask

    // Well-formed padded encoding of a byte string
    function automatic b64_byte_q_t to_base64(b64_byte_q_t raw);
        b64_byte_q_t chars;
        int          rem;
        logic [23:0] w;
        for (int i = 0; i < raw.size(); i += 3) begin
            rem = raw.size() - i;
            if (rem > 3) rem = 3;
            w = {raw[i], (rem > 1) ? raw[i + 1] : 8'h00, (rem > 2) ? raw[i + 2] : 8'h00};
            for (int k = 0; k < 4; k++) begin
                chars.push_back((k <= rem) ? checker_h.b64_char(6'(w >> (18 - 6 * k)))
                                           : b64_pkg::PAD_CHAR);
            end
        end
        return chars;
    endfunction

    function automatic b64_byte_q_t random_bytes(int n);
        b64_byte_q_t q;
        int          pick;
        repeat (n) begin
            pick = $urandom_range(0, 15);
            q.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
        end
        return q;
    endfunction

    task automatic random_encode_message();
        send_bytes(random_bytes($urandom_range(1, 9)), $urandom_range(0, 5) != 0);
    endtask

    // Mostly valid encodings; the rest are corrupted, truncated or noise
    task automatic random_decode_message();
        b64_byte_q_t chars;
        int          kind;
        kind  = $urandom_range(0, 9);
        chars = to_base64(random_bytes($urandom_range(1, 7)));
        if (kind == 7) begin
            chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
        end else if (kind == 9) begin
            repeat ($urandom_range(1, 3)) void'(chars.pop_back());
        end
        if (kind == 8) begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
            // leave tlast off now and then so padded groups run back to back
            send_bytes(chars, kind != 6);
        end
    endtask

    initial begin
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed encode: single byte, extreme bytes, a full group
        send_bytes('{8'h00}, 1'b1);
        send_bytes('{8'hFF, 8'h80}, 1'b1);
        send_text("Man", 1'b1);

        // Directed decode: full alphabet edge, pad bits, misplaced pads, bad and short
        write_direction(b64_pkg::DIR_DECODE);
        send_text("+/9z", 1'b1);
        send_text("TR==", 1'b1);
        send_text("=", 1'b0);
        send_text("A=", 1'b0);
        send_text("AB=A", 1'b0);
        send_text("AB!", 1'b1);
        send_text("Q", 1'b1);
        send_bytes('{8'hFF}, 1'b0);

        // Random phases, alternating direction
        for (int phase = 0; phase < 8; phase++) begin
            write_direction((phase % 2 == 0) ? b64_pkg::DIR_ENCODE : b64_pkg::DIR_DECODE);
            gaps_on       = $urandom_range(0, 3) != 0;
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0101);
            if (phase == 2 || phase == 5) begin
                // long receiver hold-off while the sender keeps pushing
                gaps_on       = 1'b0;
                hold_requests <= hold_requests + 1;
            end
            target = items_sent + PHASE_SIZE;
            while (items_sent < target) begin
                if (phase % 2 == 0) random_encode_message();
                else random_decode_message();
            end
        end

        drain();
        if (checker_h.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(400000 * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end
endmodule
